/* hdl/vid_pkg.sv */
// shared constants and types of the visibility integrate-and-dump block
`default_nettype none
package vid_pkg;

  localparam int SUBBANDS    = 8;
  localparam int CELLS       = 2048;
  localparam int DEPTH       = SUBBANDS * CELLS;
  localparam int ADDR_W      = $clog2(DEPTH);

  localparam int SB_W        = 3;
  localparam int CELL_W      = 11;
  localparam int CNT_W       = 16;
  localparam int WGT_W       = 17;
  localparam int PROD_W      = 32;
  localparam int SUM_W       = 48;
  localparam int NPROD       = 8;
  localparam int STEPS_W     = 7;
  localparam int PHASE_W     = 6;
  localparam int MAX_STEPS   = 64;

  localparam int CMDQ_DEPTH  = 4;
  localparam int CQ_PTR_W    = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH  = 4;
  localparam int RQ_PTR_W    = $clog2(RESQ_DEPTH);

  localparam logic [WGT_W-1:0] WGT_MAX = '1;

  typedef logic [ADDR_W-1:0] addr_t;

  // one classified cell update, handed from front to back
  typedef struct packed {
    addr_t                          addr;
    logic [SB_W-1:0]                subband;
    logic [CELL_W-1:0]              cell_idx;
    logic [WGT_W-1:0]               weight;
    logic                           zero_cnt;
    logic                           first;
    logic                           last;
    logic [NPROD-1:0][PROD_W-1:0]   prod;
  } cmd_t;

  // one accumulator entry as held in the store
  typedef struct packed {
    logic [WGT_W-1:0]               weight;
    logic                           flag;
    logic [NPROD-1:0][SUM_W-1:0]    sums;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one dumped cell
  typedef struct packed {
    logic [SB_W-1:0]                subband;
    logic [CELL_W-1:0]              cell_idx;
    entry_t                         acc;
  } res_t;

endpackage
`default_nettype wire

/* hdl/vid_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none
module vid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hdl/vid_front.sv */
// front end: period phase tracking, address check and weight product
`default_nettype none
module vid_front import vid_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [STEPS_W-1:0]            integrate_steps,
  input  logic [WGT_W-1:0]              weight_factor,
  input  logic                          take,
  input  logic [SB_W-1:0]               subband,
  input  logic [CELL_W-1:0]             cell_req,
  input  logic [CNT_W-1:0]              valid_count,
  input  logic [NPROD-1:0][PROD_W-1:0]  prod,
  input  logic                          end_of_step,
  output logic                          cmd_push,
  output cmd_t                          cmd
);

  logic [PHASE_W-1:0]     phase_r;
  logic [PHASE_W-1:0]     phase_nxt;
  logic [STEPS_W-1:0]     len;
  logic                   first;
  logic                   last;
  logic                   in_range;
  logic [WGT_W+CNT_W-1:0] wprod;

  always_comb begin
    if (integrate_steps == '0) begin
      len = STEPS_W'(1);
    end else if (integrate_steps > STEPS_W'(MAX_STEPS)) begin
      len = STEPS_W'(MAX_STEPS);
    end else begin
      len = integrate_steps;
    end
  end

  assign first    = (phase_r == '0);
  // phase at or past the end counts as the last step
  assign last     = (STEPS_W'(phase_r) + STEPS_W'(1)) >= len;
  assign in_range = (int'(subband) < SUBBANDS) && (int'(cell_req) < CELLS);

  assign wprod = (WGT_W+CNT_W)'(weight_factor) * (WGT_W+CNT_W)'(valid_count);

  always_comb begin
    phase_nxt = phase_r;
    if (take && end_of_step) begin
      phase_nxt = last ? '0 : phase_r + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign cmd_push     = take && in_range;
  assign cmd.addr     = ADDR_W'(subband) * ADDR_W'(CELLS) + ADDR_W'(cell_req);
  assign cmd.subband  = subband;
  assign cmd.cell_idx = cell_req;
  assign cmd.weight   = (wprod > (WGT_W+CNT_W)'(WGT_MAX)) ? WGT_MAX : wprod[WGT_W-1:0];
  assign cmd.zero_cnt = (valid_count == '0);
  assign cmd.first    = first;
  assign cmd.last     = last;
  assign cmd.prod     = prod;

endmodule
`default_nettype wire

/* hdl/vid_cmdq.sv */
// short command queue between front and back
`default_nettype none
module vid_cmdq import vid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  cmd_t                mem_r [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r;
  logic [CQ_PTR_W-1:0] rd_ptr_r;
  logic [CQ_PTR_W:0]   cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == (CQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (CQ_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (CQ_PTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/vid_back.sv */
// back end: store read-modify-write with forwarding and the result queue
`default_nettype none
module vid_back import vid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cq_empty,
  input  cmd_t cq_head,
  output logic cq_pop,
  input  logic res_pop,
  output logic res_empty,
  output res_t res_head
);

  logic                  b1_valid_r;
  cmd_t                  b1_cmd_r;
  logic                  fwd_valid_r;
  addr_t                 fwd_addr_r;
  entry_t                fwd_data_r;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                old;
  entry_t                upd;
  logic [WGT_W:0]        wsum;
  logic                  issue;

  res_t                  rq_mem_r [RESQ_DEPTH];
  logic [RQ_PTR_W-1:0]   rq_wr_ptr_r;
  logic [RQ_PTR_W-1:0]   rq_rd_ptr_r;
  logic [RQ_PTR_W:0]     rq_cnt_r;
  logic                  rq_push;
  logic                  rq_pop;
  res_t                  rq_data;

  function automatic logic [SUM_W-1:0] sext(input logic [PROD_W-1:0] v);
    return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [PROD_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W-PROD_W+1){b[PROD_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  // issue only with room for everything in flight
  assign issue  = !cq_empty &&
                  ((RQ_PTR_W+2)'(rq_cnt_r) + (RQ_PTR_W+2)'(b1_valid_r)
                   < (RQ_PTR_W+2)'(RESQ_DEPTH));
  assign cq_pop = issue;

  vid_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (b1_valid_r),
    .waddr (b1_cmd_r.addr),
    .wdata (upd),
    .raddr (cq_head.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      b1_valid_r  <= issue;
      fwd_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b1_cmd_r <= cq_head;
    end
    fwd_addr_r <= b1_cmd_r.addr;
    fwd_data_r <= upd;
  end

  // the write of the cycle before is not yet visible in the read data
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == b1_cmd_r.addr)) begin
      old = fwd_data_r;
    end else begin
      old = ram_rdata;
    end
    if (b1_cmd_r.first) begin
      wsum = {1'b0, b1_cmd_r.weight};
    end else begin
      wsum = {1'b0, old.weight} + {1'b0, b1_cmd_r.weight};
    end
    upd.weight = (wsum > {1'b0, WGT_MAX}) ? WGT_MAX : wsum[WGT_W-1:0];
    upd.flag   = b1_cmd_r.first ? b1_cmd_r.zero_cnt : (old.flag && b1_cmd_r.zero_cnt);
    for (int k = 0; k < NPROD; k++) begin
      upd.sums[k] = b1_cmd_r.first ? sext(b1_cmd_r.prod[k])
                                   : sat_add(old.sums[k], b1_cmd_r.prod[k]);
    end
  end

  assign rq_push          = b1_valid_r && b1_cmd_r.last;
  assign rq_pop           = res_pop && !res_empty;
  assign rq_data.subband  = b1_cmd_r.subband;
  assign rq_data.cell_idx = b1_cmd_r.cell_idx;
  assign rq_data.acc      = upd;
  assign res_empty        = (rq_cnt_r == '0);
  assign res_head         = rq_mem_r[rq_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_mem_r[rq_wr_ptr_r] <= rq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_ptr_r <= '0;
      rq_rd_ptr_r <= '0;
      rq_cnt_r    <= '0;
    end else begin
      if (rq_push) begin
        rq_wr_ptr_r <= rq_wr_ptr_r + RQ_PTR_W'(1);
      end
      if (rq_pop) begin
        rq_rd_ptr_r <= rq_rd_ptr_r + RQ_PTR_W'(1);
      end
      if (rq_push && !rq_pop) begin
        rq_cnt_r <= rq_cnt_r + (RQ_PTR_W+1)'(1);
      end else if (rq_pop && !rq_push) begin
        rq_cnt_r <= rq_cnt_r - (RQ_PTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/visibility_integrate_and_dump.sv */
// top level of the visibility integrate-and-dump accumulator
`default_nettype none
// Integrates correlator cells over a period of integrate_steps time steps
// (1..64; 0 acts as 1, larger values as 64) and dumps one result per cell on
// the last step. Each input transaction updates the accumulator entry at
// subband * CELLS + cell_req: weight sum (weight_factor * valid_count,
// Q1.16, saturating), all-flagged bit and four saturating 48-bit complex
// sums. On the first step of a period the stored entry is ignored, so the
// store needs no clearing pass after reset and accepts traffic at once.
// Cells out of range are dropped but end_of_step still advances the phase.
// Throughput is one transaction per clock while the result queue has room,
// set by the single read-modify-write per cycle on the 16384 x 402 bit store
// (one read and one write port); back-to-back updates of the same cell are
// forwarded around the store. A result passes through the command queue,
// the store read-modify-write stage and the result queue. The front side
// stalls (full) only when the command queue fills, which happens when
// results are not popped. Write the registers only while the block is idle.
module visibility_integrate_and_dump import vid_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      push,
  output logic                      full,
  input  logic [SB_W-1:0]           in_subband,
  input  logic [CELL_W-1:0]         in_cell_req,
  input  logic [CNT_W-1:0]          in_valid_count,
  input  logic signed [PROD_W-1:0]  in_xx_re,
  input  logic signed [PROD_W-1:0]  in_xx_im,
  input  logic signed [PROD_W-1:0]  in_xy_re,
  input  logic signed [PROD_W-1:0]  in_xy_im,
  input  logic signed [PROD_W-1:0]  in_yx_re,
  input  logic signed [PROD_W-1:0]  in_yx_im,
  input  logic signed [PROD_W-1:0]  in_yy_re,
  input  logic signed [PROD_W-1:0]  in_yy_im,
  input  logic                      in_end_of_step,
  // result channel
  output logic                      empty,
  input  logic                      pop,
  output logic [SB_W-1:0]           out_subband,
  output logic [CELL_W-1:0]         out_cell,
  output logic [WGT_W-1:0]          out_weight_sum,
  output logic                      out_all_flagged,
  output logic signed [SUM_W-1:0]   out_sum_xx_re,
  output logic signed [SUM_W-1:0]   out_sum_xx_im,
  output logic signed [SUM_W-1:0]   out_sum_xy_re,
  output logic signed [SUM_W-1:0]   out_sum_xy_im,
  output logic signed [SUM_W-1:0]   out_sum_yx_re,
  output logic signed [SUM_W-1:0]   out_sum_yx_im,
  output logic signed [SUM_W-1:0]   out_sum_yy_re,
  output logic signed [SUM_W-1:0]   out_sum_yy_im,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // register word index, byte address bits above the word offset
  localparam logic REG_INTEGRATE_STEPS = 1'b0;
  localparam logic REG_WEIGHT_FACTOR   = 1'b1;

  logic [STEPS_W-1:0]           integrate_steps_r;
  logic [WGT_W-1:0]             weight_factor_r;
  logic                         reg_idx;
  logic                         cfg_wr;

  logic                         take;
  logic [NPROD-1:0][PROD_W-1:0] prod;
  logic                         cmd_push;
  cmd_t                         cmd;
  logic                         cq_full;
  logic                         cq_empty;
  logic                         cq_pop;
  cmd_t                         cq_head;
  res_t                         res;

  // configuration registers, access without wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integrate_steps_r <= STEPS_W'(1);
      weight_factor_r   <= WGT_W'(65536);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INTEGRATE_STEPS: integrate_steps_r <= pwdata[STEPS_W-1:0];
        REG_WEIGHT_FACTOR:   weight_factor_r   <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INTEGRATE_STEPS: prdata = 32'(integrate_steps_r);
      REG_WEIGHT_FACTOR:   prdata = 32'(weight_factor_r);
      default:             prdata = '0;
    endcase
  end

  // input transaction into the front end
  assign full = cq_full;
  assign take = push && !cq_full;
  assign prod = {in_yy_im, in_yy_re, in_yx_im, in_yx_re,
                 in_xy_im, in_xy_re, in_xx_im, in_xx_re};

  vid_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .integrate_steps (integrate_steps_r),
    .weight_factor   (weight_factor_r),
    .take            (take),
    .subband         (in_subband),
    .cell_req        (in_cell_req),
    .valid_count     (in_valid_count),
    .prod            (prod),
    .end_of_step     (in_end_of_step),
    .cmd_push        (cmd_push),
    .cmd             (cmd)
  );

  // decouples classification from the store update
  vid_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd),
    .pop       (cq_pop),
    .full      (cq_full),
    .empty     (cq_empty),
    .head      (cq_head)
  );

  // store update and result queue
  vid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_empty  (cq_empty),
    .cq_head   (cq_head),
    .cq_pop    (cq_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res_head  (res)
  );

  assign out_subband     = res.subband;
  assign out_cell        = res.cell_idx;
  assign out_weight_sum  = res.acc.weight;
  assign out_all_flagged = res.acc.flag;
  assign out_sum_xx_re   = res.acc.sums[0];
  assign out_sum_xx_im   = res.acc.sums[1];
  assign out_sum_xy_re   = res.acc.sums[2];
  assign out_sum_xy_im   = res.acc.sums[3];
  assign out_sum_yx_re   = res.acc.sums[4];
  assign out_sum_yx_im   = res.acc.sums[5];
  assign out_sum_yy_re   = res.acc.sums[6];
  assign out_sum_yy_im   = res.acc.sums[7];

endmodule
`default_nettype wire

/* hdl/vid_chk.sv */
// port-level checker for the integrate-and-dump block and its bind
`default_nettype none
module vid_chk import vid_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic               pready,
  input wire logic [SB_W-1:0]    out_subband,
  input wire logic [CELL_W-1:0]  out_cell,
  input wire logic [WGT_W-1:0]   out_weight_sum,
  input wire logic [SUM_W-1:0]   out_sum_xx_re
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  // a waiting result stays until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_subband) && $stable(out_cell)
                          && $stable(out_weight_sum) && $stable(out_sum_xx_re)))
    else $error("waiting result changed without pop");

endmodule

bind visibility_integrate_and_dump vid_chk u_chk (.*);
`default_nettype wire

/* sim/vid_checker.sv */
// checker for the visibility integrate-and-dump block: predicts each dump and compares it
module vid_checker import vid_pkg::*; #(
  parameter logic [2:0] STEPS_ADDR = 3'd0,
  parameter logic [2:0] WFACT_ADDR = 3'd4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           full,
  input  logic [SB_W-1:0]                in_subband,
  input  logic [CELL_W-1:0]              in_cell_req,
  input  logic [CNT_W-1:0]               in_valid_count,
  input  logic [NPROD-1:0][PROD_W-1:0]   in_prod,
  input  logic                           in_end_of_step,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [SB_W-1:0]                out_subband,
  input  logic [CELL_W-1:0]              out_cell,
  input  logic [WGT_W-1:0]               out_weight_sum,
  input  logic                           out_all_flagged,
  input  logic [NPROD-1:0][SUM_W-1:0]    out_sums,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int                             n_fail,
  output int                             n_pending
);

  typedef struct packed {
    logic [SB_W-1:0]               subband;
    logic [CELL_W-1:0]             cell_idx;
    logic [WGT_W-1:0]              weight;
    logic                          flag;
    logic [NPROD-1:0][SUM_W-1:0]   sums;
  } dump_t;

  logic [STEPS_W-1:0]            steps_reg;
  logic [WGT_W-1:0]              wfact_reg;
  logic [PHASE_W-1:0]            step_phase;
  logic [WGT_W-1:0]              wgt_acc [DEPTH];
  bit                            flag_acc [DEPTH];
  logic [NPROD-1:0][SUM_W-1:0]   sum_acc [DEPTH];
  dump_t                         due_dumps [$];
  int                            fails = 0;

  // 48-bit saturating add of a sign-extended product
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [PROD_W-1:0] val);
    logic signed [SUM_W:0] s;
    s = $signed({acc[SUM_W-1], acc}) +
        $signed({{(SUM_W-PROD_W+1){val[PROD_W-1]}}, val});
    if (s[SUM_W] != s[SUM_W-1])
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return s[SUM_W-1:0];
  endfunction

  // fold one accepted transaction into its cell, queue a dump on the last step
  task automatic fold_cell();
    int unsigned                 len;
    bit                          first;
    bit                          last;
    logic [ADDR_W-1:0]           idx;
    logic [CNT_W+WGT_W-1:0]      scaled;
    logic [WGT_W-1:0]            w;
    logic [WGT_W:0]              wsum;
    dump_t                       d;
    len = (steps_reg == 0) ? 1 : (steps_reg > MAX_STEPS) ? MAX_STEPS : steps_reg;
    first = (step_phase == 0);
    last = (int'(step_phase) + 1 >= int'(len));
    idx = {in_subband, in_cell_req};
    scaled = (CNT_W+WGT_W)'(wfact_reg) * (CNT_W+WGT_W)'(in_valid_count);
    w = (scaled > WGT_MAX) ? WGT_MAX : scaled[WGT_W-1:0];
    wsum = first ? {1'b0, w} : {1'b0, wgt_acc[idx]} + {1'b0, w};
    wgt_acc[idx] = (wsum > WGT_MAX) ? WGT_MAX : wsum[WGT_W-1:0];
    flag_acc[idx] = (in_valid_count == 0) && (first || flag_acc[idx]);
    for (int k = 0; k < NPROD; k++) begin
      sum_acc[idx][k] = first ? {{(SUM_W-PROD_W){in_prod[k][PROD_W-1]}}, in_prod[k]}
                              : sat_add(sum_acc[idx][k], in_prod[k]);
    end
    if (last) begin
      d.subband = in_subband;
      d.cell_idx = in_cell_req;
      d.weight = wgt_acc[idx];
      d.flag = flag_acc[idx];
      d.sums = sum_acc[idx];
      due_dumps.push_back(d);
    end
    if (in_end_of_step)
      step_phase = last ? '0 : step_phase + 1'b1;
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] exp_v,
                             input logic [SUM_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fails++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_dump();
    dump_t d;
    if (due_dumps.size() == 0) begin
      fails++;
      $display("%0t: unexpected dump, expected none actual subband %0d cell %0d",
               $time, out_subband, out_cell);
    end else begin
      d = due_dumps.pop_front();
      check_field("subband", d.subband, out_subband);
      check_field("cell", d.cell_idx, out_cell);
      check_field("weight_sum", d.weight, out_weight_sum);
      check_field("all_flagged", d.flag, out_all_flagged);
      for (int k = 0; k < NPROD; k++)
        check_field($sformatf("sum[%0d]", k), d.sums[k], out_sums[k]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      steps_reg = STEPS_W'(1);
      wfact_reg = 17'd65536;
      step_phase = '0;
      due_dumps.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == STEPS_ADDR)
          steps_reg = pwdata[STEPS_W-1:0];
        else if (paddr == WFACT_ADDR)
          wfact_reg = pwdata[WGT_W-1:0];
      end
      if (push && !full)
        fold_cell();
      if (pop && !empty)
        check_dump();
    end
    n_fail <= fails;
    n_pending <= due_dumps.size();
  end

endmodule

/* sim/tb_visibility_integrate_and_dump.sv */
// testbench top of the visibility integrate-and-dump block: stimulus, reset and verdict
module tb_visibility_integrate_and_dump;
  import vid_pkg::*;

  // register map, one 32-bit word per register
  localparam logic [2:0]        STEPS_ADDR   = 3'd0;
  localparam logic [2:0]        WFACT_ADDR   = 3'd4;
  localparam int                N_RANDOM     = 1350;
  localparam int                CYCLE_LIMIT  = 400000;
  // leave margin after the last dump before touching registers
  localparam int                DRAIN_CYCLES = 8;
  localparam logic [PROD_W-1:0] PROD_MAX     = 32'h7FFF_FFFF;
  localparam logic [PROD_W-1:0] PROD_MIN     = 32'h8000_0000;
  localparam logic [WGT_W-1:0]  WF_ONE       = 17'd65536;
  localparam logic [WGT_W-1:0]  WF_TOP       = 17'd131071;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          push;
  logic                          full;
  logic [SB_W-1:0]               in_subband;
  logic [CELL_W-1:0]             in_cell_req;
  logic [CNT_W-1:0]              in_valid_count;
  logic [NPROD-1:0][PROD_W-1:0]  in_prod;
  logic                          in_end_of_step;
  logic                          empty;
  logic                          pop;
  logic [SB_W-1:0]               out_subband;
  logic [CELL_W-1:0]             out_cell;
  logic [WGT_W-1:0]              out_weight_sum;
  logic                          out_all_flagged;
  wire  [NPROD-1:0][SUM_W-1:0]   out_sums;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  int                            n_fail;
  int                            n_pending;

  // stimulus-side view of the period, so no unwritten entry is ever read
  logic [STEPS_W-1:0]            steps_now;
  logic [PHASE_W-1:0]            phase_now;
  bit                            written [DEPTH];
  logic [ADDR_W-1:0]             written_q [$];
  int                            n_items;
  int                            cycles;
  bit                            tx_burst;
  bit                            rx_burst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  visibility_integrate_and_dump u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_subband      (in_subband),
    .in_cell_req     (in_cell_req),
    .in_valid_count  (in_valid_count),
    .in_xx_re        (in_prod[0]),
    .in_xx_im        (in_prod[1]),
    .in_xy_re        (in_prod[2]),
    .in_xy_im        (in_prod[3]),
    .in_yx_re        (in_prod[4]),
    .in_yx_im        (in_prod[5]),
    .in_yy_re        (in_prod[6]),
    .in_yy_im        (in_prod[7]),
    .in_end_of_step  (in_end_of_step),
    .empty           (empty),
    .pop             (pop),
    .out_subband     (out_subband),
    .out_cell        (out_cell),
    .out_weight_sum  (out_weight_sum),
    .out_all_flagged (out_all_flagged),
    .out_sum_xx_re   (out_sums[0]),
    .out_sum_xx_im   (out_sums[1]),
    .out_sum_xy_re   (out_sums[2]),
    .out_sum_xy_im   (out_sums[3]),
    .out_sum_yx_re   (out_sums[4]),
    .out_sum_yx_im   (out_sums[5]),
    .out_sum_yy_re   (out_sums[6]),
    .out_sum_yy_im   (out_sums[7]),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  vid_checker #(
    .STEPS_ADDR (STEPS_ADDR),
    .WFACT_ADDR (WFACT_ADDR)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_subband      (in_subband),
    .in_cell_req     (in_cell_req),
    .in_valid_count  (in_valid_count),
    .in_prod         (in_prod),
    .in_end_of_step  (in_end_of_step),
    .empty           (empty),
    .pop             (pop),
    .out_subband     (out_subband),
    .out_cell        (out_cell),
    .out_weight_sum  (out_weight_sum),
    .out_all_flagged (out_all_flagged),
    .out_sums        (out_sums),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .n_fail          (n_fail),
    .n_pending       (n_pending)
  );

  // effective period length, register 0 acts as 1 and anything above 64 as 64
  function automatic int unsigned period_of(input logic [STEPS_W-1:0] steps);
    if (steps == 0)
      return 1;
    if (steps > MAX_STEPS)
      return MAX_STEPS;
    return steps;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input int sb, input int cell_no);
    return {sb[SB_W-1:0], cell_no[CELL_W-1:0]};
  endfunction

  // a random cell, with the edges of the cell range favored
  function automatic logic [ADDR_W-1:0] fresh_addr();
    int sb;
    int cell_no;
    sb = $urandom_range(0, SUBBANDS-1);
    case ($urandom_range(0, 3))
      0:       cell_no = 0;
      1:       cell_no = CELLS-1;
      default: cell_no = $urandom_range(0, CELLS-1);
    endcase
    return addr_of(sb, cell_no);
  endfunction

  // new cells only on the first step of a period, otherwise reuse
  function automatic logic [ADDR_W-1:0] pick_addr();
    if (phase_now == 0 && (written_q.size() == 0 || $urandom_range(0, 2) != 0))
      return fresh_addr();
    return written_q[$urandom_range(0, written_q.size()-1)];
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CNT_W'($urandom_range(1, 3));
      3:       return CNT_W'($urandom_range(0, 255));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  function automatic logic [NPROD-1:0][PROD_W-1:0] rand_prods();
    logic [NPROD-1:0][PROD_W-1:0] p;
    for (int k = 0; k < NPROD; k++) begin
      case ($urandom_range(0, 15))
        0:       p[k] = PROD_MAX;
        1:       p[k] = PROD_MIN;
        2:       p[k] = '0;
        3:       p[k] = '1;
        default: p[k] = $urandom;
      endcase
    end
    return p;
  endfunction

  function automatic logic [STEPS_W-1:0] pick_steps();
    case ($urandom_range(0, 19))
      0:          return '0;
      1:          return STEPS_W'($urandom_range(MAX_STEPS+1, 127));
      2:          return STEPS_W'(MAX_STEPS);
      3:          return STEPS_W'($urandom_range(9, MAX_STEPS-1));
      4, 5, 6, 7: return STEPS_W'(1);
      default:    return STEPS_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] pick_wfact();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WF_ONE;
      2:       return WF_TOP;
      3:       return WGT_W'(WF_ONE - 1);
      4:       return WGT_W'($urandom_range(0, WF_TOP));
      default: return WGT_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // one input transaction; push stays high afterwards so back-to-back items
  // need no lowering within the same step
  task automatic send_cell(input logic [ADDR_W-1:0] addr, input logic [CNT_W-1:0] cnt,
                           input logic [NPROD-1:0][PROD_W-1:0] prods, input logic eos);
    int                gap;
    logic [ADDR_W-1:0] a;
    a = addr;
    // past the first step only cells already stored may be touched
    if (phase_now != 0 && !written[a])
      a = written_q[$urandom_range(0, written_q.size()-1)];
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_subband <= a[ADDR_W-1 -: SB_W];
    in_cell_req <= a[CELL_W-1:0];
    in_valid_count <= cnt;
    in_prod <= prods;
    in_end_of_step <= eos;
    do @(posedge clk); while (full);
    n_items++;
    if (!written[a]) begin
      written[a] = 1'b1;
      written_q.push_back(a);
    end
    if (eos)
      phase_now = (int'(phase_now) + 1 >= int'(period_of(steps_now))) ? '0
                                                                        : phase_now + 1'b1;
  endtask

  // wait until every expected dump is out, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle; only called with the block idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == STEPS_ADDR)
      steps_now = data[STEPS_W-1:0];
  endtask

  task automatic configure(input logic [STEPS_W-1:0] steps, input logic [WGT_W-1:0] wf);
    write_reg(STEPS_ADDR, 32'(steps));
    write_reg(WFACT_ADDR, 32'(wf));
  endtask

  // a pool of cells visited on every step up to the end of the period;
  // a broken run drops cells, flips end-of-step marks and runs over or short
  task automatic run_period(input bit broken);
    logic [ADDR_W-1:0] pool [$];
    int                n_cells;
    int                n_steps;
    int                start;
    int unsigned       len;
    logic              eos;
    len = period_of(steps_now);
    n_cells = (len > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
    for (int i = 0; i < n_cells; i++)
      pool.push_back(pick_addr());
    n_steps = (phase_now < len) ? len - phase_now : 1;
    if (broken)
      n_steps = $urandom_range(1, n_steps + 2);
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int s = 0; s < n_steps; s++) begin
      start = $urandom_range(0, n_cells-1);
      for (int c = 0; c < n_cells; c++) begin
        if (broken && $urandom_range(0, 5) == 0)
          continue;
        eos = (c == n_cells-1);
        if (broken && $urandom_range(0, 3) == 0)
          eos = !eos;
        send_cell(pool[(start + c) % n_cells], rand_count(), rand_prods(), eos);
      end
    end
  endtask

  // result side: pop stalls at random before each dump, with stall-free stretches
  initial begin
    int stall;
    pop <= 1'b0;
    rx_burst = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0)
        rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("visibility_integrate_and_dump: mismatch");
      $finish;
    end
  end

  initial begin
    int base;
    cycles = 0;
    n_items = 0;
    steps_now = STEPS_W'(1);
    phase_now = '0;
    tx_burst = 1'b0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_subband <= '0;
    in_cell_req <= '0;
    in_valid_count <= '0;
    in_prod <= '0;
    in_end_of_step <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings pass every transaction straight through at weight 1.0:
    // all-zero flagged cell, top corner with saturated weight, minimum
    // products without end of step, weight just past the Q1.16 limit
    send_cell(addr_of(0, 0), '0, '0, 1'b1);
    send_cell(addr_of(SUBBANDS-1, CELLS-1), '1, {NPROD{PROD_MAX}}, 1'b1);
    send_cell(addr_of(3, 1024), 16'd1, {NPROD{PROD_MIN}}, 1'b0);
    send_cell(addr_of(5, 5), 16'd2, {(NPROD/2){PROD_MIN, PROD_MAX}}, 1'b1);

    // two-step period: weight sum saturating on the add, a cell flagged on
    // both steps, and a cell that loses its flag on the second step
    configure(STEPS_W'(2), WGT_W'(WF_ONE - 1));
    for (int s = 0; s < 2; s++) begin
      send_cell(addr_of(1, 100), 16'(s + 1), {NPROD{PROD_MAX}}, 1'b0);
      send_cell(addr_of(2, 200), '0, {NPROD{PROD_MIN}}, 1'b0);
      send_cell(addr_of(6, CELLS-2), 16'(3 * s), rand_prods(), 1'b1);
    end

    // factor above 1.0, the product reaches the top of the weight range
    configure(STEPS_W'(1), WF_TOP);
    send_cell(addr_of(1, 100), 16'd1, rand_prods(), 1'b0);
    send_cell(addr_of(2, 200), '0, rand_prods(), 1'b1);

    // zero factor: weight stays zero while the flag still follows the count
    configure(STEPS_W'(3), '0);
    for (int s = 0; s < 3; s++) begin
      send_cell(addr_of(1, 100), '1, {NPROD{PROD_MAX}}, 1'b0);
      send_cell(addr_of(2, 200), '0, {NPROD{PROD_MIN}}, 1'b1);
    end

    // shrink the period under a running phase: the next item counts as last
    configure(STEPS_W'(8), WF_ONE);
    for (int s = 0; s < 3; s++)
      send_cell(addr_of(1, 100), rand_count(), rand_prods(), 1'b1);
    write_reg(STEPS_ADDR, 32'd2);
    send_cell(addr_of(1, 100), rand_count(), rand_prods(), 1'b1);

    // period register zero behaves as one
    write_reg(STEPS_ADDR, 32'd0);
    send_cell(addr_of(2, 200), rand_count(), rand_prods(), 1'b1);

    // random settings, mostly whole periods with random content
    base = n_items;
    while (n_items - base < N_RANDOM) begin
      configure(pick_steps(), pick_wfact());
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0)
          send_cell(pick_addr(), rand_count(), rand_prods(), 1'($urandom_range(0, 1)));
        run_period($urandom_range(0, 7) == 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (n_fail == 0)
      $display("visibility_integrate_and_dump: match");
    else
      $display("visibility_integrate_and_dump: mismatch");
    $finish;
  end

endmodule
